>>> src/glob_wildcard_matcher_macros.svh
// assertion macros for the glob matcher
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define GWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define GWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/gwm_pkg.sv
package gwm_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned PtrW       = $clog2(MaxPattern);
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);

  localparam logic [7:0] CharQuest  = 8'h3F;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharLbrack = 8'h5B;
  localparam logic [7:0] CharRbrack = 8'h5D;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharDot    = 8'h2E;

  localparam logic CfgCaseExact  = 1'b0;
  localparam logic CfgLeadingDot = 1'b1;

  typedef enum logic [1:0] {
    ModeClear  = 2'd0,
    ModeAppend = 2'd1,
    ModeText   = 2'd2,
    ModeEnd    = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StSweep  = 5'b00010,
    StEsc    = 5'b00100,
    StSet    = 5'b01000,
    StResult = 5'b10000
  } state_e;

  typedef enum logic [5:0] {
    SsOpen  = 6'b000001,
    SsItem  = 6'b000010,
    SsEsc   = 6'b000100,
    SsAfter = 6'b001000,
    SsDash  = 6'b010000,
    SsHiEsc = 6'b100000
  } set_state_e;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic esc;
    logic set_step;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic end_text;
    logic go_esc;
    logic go_set;
    logic set_done;
  } status_t;

  function automatic logic [7:0] fold(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v >= 8'h41 && v <= 8'h5A) r = v + 8'd32;
    return r;
  endfunction

  function automatic logic in_range(input logic [7:0] b, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return ($signed(b) >= $signed(lo)) && ($signed(b) <= $signed(hi));
  endfunction

endpackage

>>> src/glob_wildcard_matcher.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: mode, byte_value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: matched, pattern_overflow
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// clear and pattern bytes are taken in the idle state; a nonzero text byte sweeps
// every pattern position, with an extra escape step per active escape and set
// steps through each active bracket set, all set by the single read port of the store.
// end of text sweeps every position, then holds the result until it is taken.
// reset is asynchronous; the store needs no clearing pass.
// one transaction is in work at a time; input waits while a result stalls.
module glob_wildcard_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // mode[1:0], byte_value[9:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // matched[0], pattern_overflow[1]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i
);
  import gwm_pkg::*;
  `include "glob_wildcard_matcher_macros.svh"

  cmd_t       cmd;
  status_t    status;
  mode_e      mode;
  logic [7:0] byte_value;
  logic       matched, povf;

  assign mode       = mode_e'(s_axis_tdata[1:0]);
  assign byte_value = s_axis_tdata[9:2];

  gwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .mode_i     (mode),
    .byte_nz_i  (byte_value != 8'd0),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .cmd_o      (cmd)
  );

  gwm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mode_i     (mode),
    .byte_i     (byte_value),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .status_o   (status),
    .matched_o  (matched),
    .povf_o     (povf)
  );

  assign m_axis_tdata = {6'd0, povf, matched};

  `GWM_ASSERT_ALWAYS(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "input taken while result pending")
  `GWM_ASSERT(a_ovf_no_match, m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0], "match despite overflow")
  `GWM_ASSERT(a_zero_text, s_axis_tvalid && s_axis_tready && mode == ModeText && byte_value == 8'd0 |=> s_axis_tready, "zero text byte not ignored")

endmodule

>>> src/gwm_ram.sv
module gwm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/gwm_ctrl.sv
module gwm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  gwm_pkg::mode_e  mode_i,
  input  logic            byte_nz_i,
  input  logic            out_ready_i,
  input  gwm_pkg::status_t status_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output gwm_pkg::cmd_t   cmd_o
);
  import gwm_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if ((mode_i == ModeText && byte_nz_i) || mode_i == ModeEnd) state_d = StSweep;
        end
      end
      StSweep: begin
        cmd_o.sweep = 1'b1;
        priority if (status_i.at_end) begin
          state_d = status_i.end_text ? StResult : StIdle;
        end else if (status_i.go_esc) begin
          state_d = StEsc;
        end else if (status_i.go_set) begin
          state_d = StSet;
        end
      end
      StEsc: begin
        cmd_o.esc = 1'b1;
        state_d = StSweep;
      end
      StSet: begin
        cmd_o.set_step = 1'b1;
        if (status_i.set_done) state_d = StSweep;
      end
      StResult: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/gwm_datapath.sv
module gwm_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gwm_pkg::cmd_t    cmd_i,
  input  gwm_pkg::mode_e   mode_i,
  input  logic [7:0]       byte_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic             cfg_wdata_i,
  output gwm_pkg::status_t status_o,
  output logic             matched_o,
  output logic             povf_o
);
  import gwm_pkg::*;

  logic [LenW-1:0] len_q, len_d, i_q, i_d, rp_q, rp_d;
  logic            ovf_q, ovf_d, at_start_q, at_start_d;
  logic            carry_q, carry_d, block_q, block_d, end_q, end_d;
  logic [MaxPattern:0] active_q, active_d, nxt_q, nxt_d;
  logic [7:0]      byte_q, byte_d, lo_q, lo_d;
  set_state_e      sst_q, sst_d;
  logic            inv_q, inv_d, hit_q, hit_d, first_q, first_d;
  logic            ce_q, lds_q;
  logic            matched_q, matched_d, povf_q, povf_d;

  logic            we;
  logic [7:0]      p;
  logic            cur, inr, at_end;
  logic            do_item, hit_eff, set_done;
  logic [MaxPattern:0] restart_vec;

  gwm_ram #(.Width(8), .Depth(MaxPattern)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(len_q[PtrW-1:0]),
    .wdata_i(byte_i),
    .raddr_i(rp_d[PtrW-1:0]),
    .rdata_o(p)
  );

  assign restart_vec = (MaxPattern + 1)'(1);
  assign cur    = active_q[i_q] | carry_q;
  assign inr    = rp_q < len_q;
  assign at_end = i_q >= len_q;

  always_comb begin
    len_d = len_q; ovf_d = ovf_q; at_start_d = at_start_q;
    i_d = i_q; rp_d = rp_q; carry_d = carry_q; block_d = block_q; end_d = end_q;
    active_d = active_q; nxt_d = nxt_q; byte_d = byte_q; lo_d = lo_q;
    sst_d = sst_q; inv_d = inv_q; hit_d = hit_q; first_d = first_q;
    matched_d = matched_q; povf_d = povf_q;
    we = 1'b0; do_item = 1'b0; hit_eff = hit_q; set_done = 1'b0;

    if (cmd_i.accept) begin
      unique case (mode_i)
        ModeClear: begin
          len_d = '0; ovf_d = 1'b0;
          active_d = restart_vec; at_start_d = 1'b1;
        end
        ModeAppend: begin
          if (byte_i != 8'd0) begin
            if (len_q < LenW'(MaxPattern)) begin
              we = 1'b1;
              len_d = len_q + LenW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          active_d = restart_vec; at_start_d = 1'b1;
        end
        ModeText: begin
          if (byte_i != 8'd0) begin
            byte_d = byte_i;
            block_d = lds_q & at_start_q & (byte_i == CharDot);
            end_d = 1'b0; i_d = '0; rp_d = '0; carry_d = 1'b0; nxt_d = '0;
          end
        end
        ModeEnd: begin
          block_d = 1'b0; end_d = 1'b1; i_d = '0; rp_d = '0; carry_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.sweep) begin
      if (at_end) begin
        if (end_q) begin
          matched_d = ~ovf_q & cur;
          povf_d = ovf_q;
          active_d = restart_vec; at_start_d = 1'b1;
        end else begin
          active_d = nxt_q; at_start_d = 1'b0;
        end
      end else begin
        i_d = i_q + LenW'(1); rp_d = i_q + LenW'(1); carry_d = 1'b0;
        if (cur) begin
          if (end_q) begin
            carry_d = (p == CharStar);
          end else begin
            priority case (p)
              CharStar: begin
                if (!block_q) begin
                  nxt_d[i_q] = 1'b1;
                  carry_d = 1'b1;
                end
              end
              CharQuest: if (!block_q) nxt_d[i_q + LenW'(1)] = 1'b1;
              CharBslash: i_d = i_q;
              CharLbrack: begin
                i_d = i_q; sst_d = SsOpen;
                hit_d = 1'b0; inv_d = 1'b0; first_d = 1'b1;
              end
              default: begin
                if (ce_q ? (p == byte_q) : (fold(p) == fold(byte_q)))
                  nxt_d[i_q + LenW'(1)] = 1'b1;
              end
            endcase
          end
        end
      end
    end

    if (cmd_i.esc) begin
      if (inr && p == byte_q) nxt_d[i_q + LenW'(2)] = 1'b1;
      i_d = i_q + LenW'(1);
    end

    if (cmd_i.set_step) begin
      if (!inr) begin
        set_done = 1'b1;
      end else begin
        unique case (sst_q)
          SsOpen: begin
            if (p == CharBang || p == CharCaret) begin
              inv_d = 1'b1; sst_d = SsItem; rp_d = rp_q + LenW'(1);
            end else begin
              do_item = 1'b1;
            end
          end
          SsItem: do_item = 1'b1;
          SsEsc: begin
            lo_d = p; sst_d = SsAfter; rp_d = rp_q + LenW'(1);
          end
          SsAfter: begin
            if (p == CharDash) begin
              sst_d = SsDash; rp_d = rp_q + LenW'(1);
            end else begin
              hit_eff = hit_q | in_range(byte_q, lo_q, lo_q);
              do_item = 1'b1;
            end
          end
          SsDash: begin
            if (p == CharRbrack) begin
              hit_eff = hit_q | in_range(byte_q, lo_q, lo_q) | (byte_q == CharDash);
              do_item = 1'b1;
            end else if (p == CharBslash) begin
              sst_d = SsHiEsc; rp_d = rp_q + LenW'(1);
            end else begin
              hit_d = hit_q | in_range(byte_q, lo_q, p);
              sst_d = SsItem; rp_d = rp_q + LenW'(1);
            end
          end
          SsHiEsc: begin
            hit_d = hit_q | in_range(byte_q, lo_q, p);
            sst_d = SsItem; rp_d = rp_q + LenW'(1);
          end
          default: set_done = 1'b1;
        endcase
        if (do_item) begin
          hit_d = hit_eff;
          first_d = 1'b0;
          rp_d = rp_q + LenW'(1);
          if (!first_q && p == CharRbrack) begin
            set_done = 1'b1;
            if (hit_eff != inv_q) nxt_d[rp_q + LenW'(1)] = 1'b1;
          end else if (p == CharBslash) begin
            sst_d = SsEsc;
          end else begin
            lo_d = p; sst_d = SsAfter;
          end
        end
      end
      if (set_done) begin
        i_d = i_q + LenW'(1); rp_d = i_q + LenW'(1);
      end
    end
  end

  assign status_o.at_end   = at_end;
  assign status_o.end_text = end_q;
  assign status_o.go_esc   = ~at_end & cur & ~end_q & (p == CharBslash);
  assign status_o.go_set   = ~at_end & cur & ~end_q & (p == CharLbrack);
  assign status_o.set_done = set_done;
  assign matched_o = matched_q;
  assign povf_o    = povf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; ovf_q <= 1'b0; at_start_q <= 1'b1;
      active_q <= (MaxPattern + 1)'(1);
      i_q <= '0; rp_q <= '0; carry_q <= 1'b0; end_q <= 1'b0;
      sst_q <= SsOpen;
      ce_q <= 1'b1; lds_q <= 1'b0;
    end else begin
      len_q <= len_d; ovf_q <= ovf_d; at_start_q <= at_start_d;
      active_q <= active_d;
      i_q <= i_d; rp_q <= rp_d; carry_q <= carry_d; end_q <= end_d;
      sst_q <= sst_d;
      if (cfg_we_i && cfg_idx_i == CfgCaseExact) ce_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CfgLeadingDot) lds_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d; byte_q <= byte_d; lo_q <= lo_d; block_q <= block_d;
    inv_q <= inv_d; hit_q <= hit_d; first_q <= first_d;
    matched_q <= matched_d; povf_q <= povf_d;
  end

endmodule
